// File: hdl/qstp_pkg.sv
// Shared types, codes and arithmetic constants for the quintic segment player.
package qstp_pkg;

  localparam int unsigned COEFF_W_DEF = 32;
  localparam int unsigned TIME_W_DEF  = 32;
  localparam int unsigned ID_W_DEF    = 16;
  localparam int unsigned ACC_W       = 56;
  localparam int unsigned NCOEF       = 6;
  localparam int unsigned FRAC_T      = 24;
  localparam int unsigned STEP_W      = 24;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd16777;
  localparam int unsigned START_ID    = 2;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_SYNC  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PS_IDLE   = 2'd0,
    PS_WAIT   = 2'd1,
    PS_ACTIVE = 2'd2
  } player_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_ACT  = 3'd1,
    ST_WAITING  = 3'd2,
    ST_BAD_NEXT = 3'd3,
    ST_BAD_START = 3'd4,
    ST_BUSY     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EVAL,
    SQ_MUL,
    SQ_ADD,
    SQ_FIN,
    SQ_OUT
  } seq_e;

  // handshake between sequencer and Horner unit
  typedef struct packed {
    logic start;
  } hrn_ctl_t;

  typedef struct packed {
    logic done;
  } hrn_sts_t;

endpackage

// File: hdl/qstp_horner.sv
// Horner evaluator: one shared half-width multiplier, one coefficient step per pass.
module qstp_horner #(
  parameter int unsigned COEFF_WIDTH = qstp_pkg::COEFF_W_DEF,
  parameter int unsigned TIME_WIDTH  = qstp_pkg::TIME_W_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  qstp_pkg::hrn_ctl_t                     ctl_i,
  input  logic [qstp_pkg::NCOEF-1:0][COEFF_WIDTH-1:0] coeff_i,
  input  logic [TIME_WIDTH-1:0]                  t_i,
  output qstp_pkg::hrn_sts_t                     sts_o,
  output logic signed [31:0]                     result_o
);
  localparam int unsigned AW   = qstp_pkg::ACC_W;
  localparam int unsigned PW   = AW + TIME_WIDTH;
  localparam int unsigned HW   = AW / 2;
  localparam int unsigned MW   = HW + TIME_WIDTH;
  localparam int unsigned KW   = $clog2(qstp_pkg::NCOEF);
  localparam logic [AW:0] LIM  = {1'b1, {AW{1'b0}}};

  // each pass: low half product, high half product, then round/add/saturate
  typedef enum logic [1:0] {H_IDLE, H_MUL, H_MUL2, H_ADD} hst_e;

  hst_e               st_q, st_d;
  logic [KW-1:0]      k_q, k_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic               neg_q, neg_d;
  logic               done_q, done_d;
  logic [AW-1:0]      mag;
  logic [HW-1:0]      mop;
  logic [MW-1:0]      mp;
  logic [PW:0]        rnd;
  logic [AW:0]        pmag;
  logic signed [AW+1:0] sum;
  logic signed [AW-1:0] ck;
  logic signed [AW+1:0] hi_lim, lo_lim;

  assign mag    = acc_q[AW-1] ? AW'(-acc_q) : acc_q;
  assign mop    = (st_q == H_MUL2) ? mag[AW-1:HW] : mag[HW-1:0];
  assign mp     = MW'(mop) * MW'(t_i);
  assign rnd    = {1'b0, prod_q} + (PW+1)'(1 << (qstp_pkg::FRAC_T - 1));
  // magnitude after rounding, clamped to 2^(AW)
  always_comb begin
    if (rnd[PW:qstp_pkg::FRAC_T] > (PW+1-qstp_pkg::FRAC_T)'(LIM)) pmag = LIM;
    else pmag = rnd[qstp_pkg::FRAC_T +: AW+1];
  end
  assign ck     = AW'(signed'(coeff_i[k_q]));
  assign hi_lim = (AW+2)'(signed'({1'b0, {(AW-1){1'b1}}}));
  assign lo_lim = -hi_lim - (AW+2)'(1);
  always_comb begin
    logic signed [AW+1:0] sp;
    sp  = neg_q ? -signed'({1'b0, pmag}) : signed'({1'b0, pmag});
    sum = sp + (AW+2)'(ck);
  end

  always_comb begin
    st_d = st_q; k_d = k_q; acc_d = acc_q; prod_d = prod_q; neg_d = neg_q;
    done_d = 1'b0;
    case (st_q)
      H_IDLE: begin
        if (ctl_i.start) begin
          acc_d = AW'(signed'(coeff_i[qstp_pkg::NCOEF-1]));
          k_d   = KW'(qstp_pkg::NCOEF-2);
          st_d  = H_MUL;
        end
      end
      H_MUL: begin
        prod_d = PW'(mp);
        neg_d  = acc_q[AW-1];
        st_d   = H_MUL2;
      end
      H_MUL2: begin
        prod_d = prod_q + (PW'(mp) << HW);
        st_d   = H_ADD;
      end
      H_ADD: begin
        if (sum > hi_lim) acc_d = hi_lim[AW-1:0];
        else if (sum < lo_lim) acc_d = lo_lim[AW-1:0];
        else acc_d = sum[AW-1:0];
        if (k_q == '0) begin
          st_d = H_IDLE; done_d = 1'b1;
        end else begin
          k_d = k_q - KW'(1); st_d = H_MUL;
        end
      end
      default: st_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= H_IDLE; done_q <= 1'b0;
    end else begin
      st_q <= st_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    k_q <= k_d; acc_q <= acc_d; prod_q <= prod_d; neg_q <= neg_d;
  end

  assign sts_o.done = done_q;
  always_comb begin
    if (acc_q > AW'(signed'(32'h7fffffff))) result_o = 32'sh7fffffff;
    else if (acc_q < AW'(signed'(32'h80000000))) result_o = 32'sh80000000;
    else result_o = acc_q[31:0];
  end
endmodule

// File: hdl/quintic_segment_trajectory_player.sv
// Top level: APB register, request checks, segment stores and tick sequencer.
// Each transfer returns one result. Start, load and sync requests go from idle
// straight to the output state; a tick first passes the idle/wait transition
// state and, if the segment is active, evaluates it with five Horner passes
// through the single shared multiplier (low half product, high half product,
// then round/add/saturate). Results are held in an output register, and the
// block takes no new input until the current result is transferred.
module quintic_segment_trajectory_player #(
  parameter int unsigned COEFF_WIDTH = qstp_pkg::COEFF_W_DEF,
  parameter int unsigned TIME_WIDTH  = qstp_pkg::TIME_W_DEF,
  parameter int unsigned ID_WIDTH    = qstp_pkg::ID_W_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] seg_id_i,
  input  logic [31:0] seg_duration_i,
  input  logic signed [31:0] coeff_0_i,
  input  logic signed [31:0] coeff_1_i,
  input  logic signed [31:0] coeff_2_i,
  input  logic signed [31:0] coeff_3_i,
  input  logic signed [31:0] coeff_4_i,
  input  logic signed [31:0] coeff_5_i,
  input  logic        wait_for_sync_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic signed [31:0] position_o,
  output logic [15:0] current_segment_o,
  output logic [1:0]  player_state_o,
  output logic [2:0]  status_o
);
  localparam int unsigned N = qstp_pkg::NCOEF;
  typedef logic [N-1:0][COEFF_WIDTH-1:0] cvec_t;

  logic [qstp_pkg::STEP_W-1:0] step_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= qstp_pkg::STEP_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) step_q <= pwdata[23:0];
  end
  assign prdata = (paddr == 2'd0) ? {8'd0, step_q} : 32'd0;

  qstp_pkg::seq_e  sq_q, sq_d;
  qstp_pkg::player_e pm_q, pm_d;
  logic [TIME_WIDTH-1:0] tm_q, tm_d;
  logic signed [31:0] pos_q, pos_d;
  logic [ID_WIDTH-1:0] shown_q, shown_d;
  cvec_t ac_q, ac_d, qc_q, qc_d, sc_q, sc_d;
  logic [TIME_WIDTH-1:0] ad_q, ad_d, qd_q, qd_d, sd_q, sd_d;
  logic [ID_WIDTH-1:0] ai_q, ai_d, qi_q, qi_d, si_q, si_d;
  logic ap_q, ap_d, qp_q, qp_d, sp_q, sp_d, ss_q, ss_d, hold_q, hold_d;
  logic [2:0] stat_q, stat_d;
  logic vo_q, vo_d;

  qstp_pkg::hrn_ctl_t hctl;
  qstp_pkg::hrn_sts_t hsts;
  logic signed [31:0] hres;
  cvec_t in_c;
  logic [ID_WIDTH-1:0] in_id;
  logic acc_in;
  logic [TIME_WIDTH:0] nt;

  assign in_c  = {COEFF_WIDTH'(coeff_5_i), COEFF_WIDTH'(coeff_4_i), COEFF_WIDTH'(coeff_3_i),
                  COEFF_WIDTH'(coeff_2_i), COEFF_WIDTH'(coeff_1_i), COEFF_WIDTH'(coeff_0_i)};
  assign in_id = ID_WIDTH'(seg_id_i);
  assign ready_o = (sq_q == qstp_pkg::SQ_IDLE) && !vo_q;
  assign acc_in  = valid_i && ready_o;
  assign nt = {1'b0, tm_q} + (TIME_WIDTH+1)'(step_q);

  qstp_horner #(.COEFF_WIDTH(COEFF_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_horner (
    .clk_i, .rst_ni, .ctl_i(hctl), .coeff_i(ac_q), .t_i(tm_q),
    .sts_o(hsts), .result_o(hres)
  );

  // next state
  always_comb begin
    sq_d = sq_q;
    case (sq_q)
      qstp_pkg::SQ_IDLE: if (acc_in) begin
        if (qstp_pkg::mode_e'(mode_i) == qstp_pkg::MODE_TICK) sq_d = qstp_pkg::SQ_FIN;
        else sq_d = qstp_pkg::SQ_OUT;
      end
      // a player that goes active on this tick is evaluated on it too
      qstp_pkg::SQ_FIN:  sq_d = (pm_d == qstp_pkg::PS_ACTIVE) ? qstp_pkg::SQ_EVAL
                                                             : qstp_pkg::SQ_OUT;
      qstp_pkg::SQ_EVAL: sq_d = qstp_pkg::SQ_MUL;
      qstp_pkg::SQ_MUL:  if (hsts.done) sq_d = qstp_pkg::SQ_ADD;
      qstp_pkg::SQ_ADD:  sq_d = qstp_pkg::SQ_OUT;
      qstp_pkg::SQ_OUT:  sq_d = qstp_pkg::SQ_IDLE;
      default: sq_d = qstp_pkg::SQ_IDLE;
    endcase
  end

  // datapath / outputs
  always_comb begin
    pm_d = pm_q; tm_d = tm_q; pos_d = pos_q; shown_d = shown_q;
    ac_d = ac_q; ad_d = ad_q; ai_d = ai_q; qc_d = qc_q; qd_d = qd_q; qi_d = qi_q;
    sc_d = sc_q; sd_d = sd_q; si_d = si_q;
    ap_d = ap_q; qp_d = qp_q; sp_d = sp_q; ss_d = ss_q; hold_d = hold_q;
    stat_d = stat_q; vo_d = vo_q; hctl.start = 1'b0;
    if (vo_q && ready_i) vo_d = 1'b0;
    case (sq_q)
      qstp_pkg::SQ_IDLE: if (acc_in) begin
        stat_d = qstp_pkg::ST_OK;
        case (qstp_pkg::mode_e'(mode_i))
          qstp_pkg::MODE_TICK: begin
            if (sp_q) begin
              if (ss_q) begin
                ac_d = sc_q; ad_d = sd_q; ai_d = si_q; ap_d = 1'b1; ss_d = 1'b0;
              end else if (sd_q != '0) begin
                qc_d = sc_q; qd_d = sd_q; qi_d = si_q; qp_d = 1'b1;
              end else qp_d = 1'b0;
              sp_d = 1'b0;
            end
          end
          qstp_pkg::MODE_START: begin
            if (pm_q == qstp_pkg::PS_IDLE) begin
              if (in_id != ID_WIDTH'(qstp_pkg::START_ID)) stat_d = qstp_pkg::ST_BAD_START;
              else begin
                sc_d = in_c; sd_d = TIME_WIDTH'(seg_duration_i); si_d = in_id;
                sp_d = 1'b1; ss_d = 1'b1; hold_d = wait_for_sync_i;
              end
            end else stat_d = (pm_q == qstp_pkg::PS_WAIT) ? qstp_pkg::ST_WAITING
                                                          : qstp_pkg::ST_BUSY;
          end
          qstp_pkg::MODE_LOAD: begin
            if (pm_q == qstp_pkg::PS_IDLE) stat_d = qstp_pkg::ST_NOT_ACT;
            else if (pm_q == qstp_pkg::PS_WAIT) stat_d = qstp_pkg::ST_WAITING;
            else if (in_id != ai_q + ID_WIDTH'(1)) stat_d = qstp_pkg::ST_BAD_NEXT;
            else begin
              sc_d = in_c; sd_d = TIME_WIDTH'(seg_duration_i); si_d = in_id;
              sp_d = 1'b1; ss_d = 1'b0;
            end
          end
          default: hold_d = 1'b0;
        endcase
      end
      qstp_pkg::SQ_FIN: begin
        // idle and wait transitions of a tick
        if (pm_q == qstp_pkg::PS_IDLE) begin
          shown_d = '0;
          if (ap_q) begin
            tm_d = '0;
            if (hold_q) begin
              pm_d = qstp_pkg::PS_WAIT; shown_d = ID_WIDTH'(1);
            end else pm_d = qstp_pkg::PS_ACTIVE;
          end
        end else if (pm_q == qstp_pkg::PS_WAIT) begin
          shown_d = ID_WIDTH'(1);
          if (!hold_q) pm_d = qstp_pkg::PS_ACTIVE;
        end
      end
      qstp_pkg::SQ_EVAL: begin
        shown_d = ai_q; hctl.start = 1'b1;
      end
      qstp_pkg::SQ_ADD: begin
        pos_d = hres;
        if (tm_q < ad_q) begin
          tm_d = (nt < {1'b0, ad_q}) ? nt[TIME_WIDTH-1:0] : ad_q;
        end else if (!qp_q) begin
          pm_d = qstp_pkg::PS_IDLE; ap_d = 1'b0; shown_d = '0;
        end else begin
          ac_d = qc_q; ad_d = qd_q; ai_d = qi_q; qp_d = 1'b0; tm_d = '0;
        end
      end
      qstp_pkg::SQ_OUT: vo_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= qstp_pkg::SQ_IDLE; pm_q <= qstp_pkg::PS_IDLE; tm_q <= '0;
      pos_q <= '0; shown_q <= '0; ap_q <= 1'b0; qp_q <= 1'b0; sp_q <= 1'b0;
      ss_q <= 1'b0; hold_q <= 1'b0; stat_q <= '0; vo_q <= 1'b0;
    end else begin
      sq_q <= sq_d; pm_q <= pm_d; tm_q <= tm_d; pos_q <= pos_d; shown_q <= shown_d;
      ap_q <= ap_d; qp_q <= qp_d; sp_q <= sp_d; ss_q <= ss_d; hold_q <= hold_d;
      stat_q <= stat_d; vo_q <= vo_d;
    end
  end
  always_ff @(posedge clk_i) begin
    ac_q <= ac_d; ad_q <= ad_d; ai_q <= ai_d; qc_q <= qc_d; qd_q <= qd_d; qi_q <= qi_d;
    sc_q <= sc_d; sd_q <= sd_d; si_q <= si_d;
  end

  assign valid_o = vo_q;
  assign position_o = pos_q;
  assign current_segment_o = 16'(shown_q);
  assign player_state_o = pm_q;
  assign status_o = stat_q;
endmodule

// File: test/quintic_segment_trajectory_player_tb.sv
// Testbench for the quintic segment trajectory player: directed table, random traffic, checks.
`timescale 1ns / 1ps
module quintic_segment_trajectory_player_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0, ready_i = 1'b0;
  logic ready_o, valid_o;
  logic [1:0] mode_i = '0;
  logic [15:0] seg_id_i = '0;
  logic [31:0] seg_duration_i = '0;
  logic signed [31:0] coeff_0_i = '0, coeff_1_i = '0, coeff_2_i = '0;
  logic signed [31:0] coeff_3_i = '0, coeff_4_i = '0, coeff_5_i = '0;
  logic wait_for_sync_i = 1'b0;
  logic signed [31:0] position_o;
  logic [15:0] current_segment_o;
  logic [1:0] player_state_o;
  logic [2:0] status_o;

  localparam logic [1:0] STEP_ADDR = 2'd0;

  quintic_segment_trajectory_player dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct {
    qstp_pkg::mode_e    mode;
    logic [15:0]        id;
    logic [31:0]        dur;
    logic signed [31:0] c [qstp_pkg::NCOEF];
    logic               sync;
  } request_t;

  typedef struct {
    logic signed [31:0] pos;
    logic [15:0]        seg;
    qstp_pkg::player_e  ps;
    qstp_pkg::status_e  st;
  } sample_t;

  typedef struct {
    logic signed [63:0] c [qstp_pkg::NCOEF];
    logic [31:0] dur;
    logic [15:0] id;
  } segment_t;

  // predictor state
  logic [23:0] step_q;
  qstp_pkg::player_e mode_q;
  logic [31:0] time_q;
  logic signed [31:0] held_q;
  logic [15:0] shown_q;
  segment_t act_q, que_q, stg_q;
  bit act_v, que_v, stg_v, stg_start, hold_q;

  sample_t pending_samples[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit quiet = 1'b0;

  function automatic logic signed [63:0] clamp(logic signed [63:0] v, int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic signed [31:0] horner(segment_t s, logic [31:0] t);
    logic signed [63:0] acc, sp;
    logic [127:0] prod;
    logic [63:0] mag, p;
    acc = s.c[qstp_pkg::NCOEF-1];
    for (int k = qstp_pkg::NCOEF - 2; k >= 0; k--) begin
      mag = acc < 0 ? 64'(-acc) : 64'(acc);
      prod = ((128'(mag) * 128'(t)) + 128'h80_0000) >> 24;
      p = prod > (128'd1 << 56) ? (64'd1 << 56) : prod[63:0];
      sp = acc < 0 ? -$signed(p) : $signed(p);
      acc = clamp(sp + s.c[k], qstp_pkg::ACC_W);
    end
    return 32'(clamp(acc, 32));
  endfunction

  task automatic player_reset();
    step_q = qstp_pkg::STEP_RESET; mode_q = qstp_pkg::PS_IDLE; time_q = 0; held_q = 0;
    shown_q = 0;
    act_v = 0; que_v = 0; stg_v = 0; stg_start = 0; hold_q = 0;
  endtask

  function automatic void advance_tick();
    logic [32:0] nt;
    if (stg_v) begin
      if (stg_start) begin
        act_q = stg_q; act_v = 1; stg_start = 0;
      end else if (stg_q.dur > 0) begin
        que_q = stg_q; que_v = 1;
      end else begin
        que_v = 0;
      end
      stg_v = 0;
    end
    if (mode_q == qstp_pkg::PS_IDLE) begin
      shown_q = 0;
      if (act_v) begin
        mode_q = hold_q ? qstp_pkg::PS_WAIT : qstp_pkg::PS_ACTIVE;
        time_q = 0;
      end
    end
    if (mode_q == qstp_pkg::PS_WAIT) begin
      shown_q = 1;
      if (!hold_q) mode_q = qstp_pkg::PS_ACTIVE;
    end
    if (mode_q == qstp_pkg::PS_ACTIVE) begin
      shown_q = act_q.id;
      held_q = horner(act_q, time_q);
      if (time_q < act_q.dur) begin
        nt = time_q + step_q;
        time_q = nt < act_q.dur ? nt[31:0] : act_q.dur;
      end else if (!que_v) begin
        mode_q = qstp_pkg::PS_IDLE; act_v = 0; shown_q = 0;
      end else begin
        act_q = que_q; que_v = 0; time_q = 0;
      end
    end
  endfunction

  function automatic void stage_segment(request_t r, bit is_start);
    for (int k = 0; k < qstp_pkg::NCOEF; k++) stg_q.c[k] = r.c[k];
    stg_q.dur = r.dur; stg_q.id = r.id;
    stg_v = 1; stg_start = is_start;
  endfunction

  function automatic sample_t predict_sample(request_t r);
    sample_t s;
    qstp_pkg::status_e st;
    st = qstp_pkg::ST_OK;
    case (r.mode)
      qstp_pkg::MODE_TICK: advance_tick();
      qstp_pkg::MODE_START: begin
        if (mode_q == qstp_pkg::PS_IDLE) begin
          if (r.id != qstp_pkg::START_ID) st = qstp_pkg::ST_BAD_START;
          else begin
            stage_segment(r, 1); hold_q = r.sync;
          end
        end else st = mode_q == qstp_pkg::PS_WAIT ? qstp_pkg::ST_WAITING
                                                  : qstp_pkg::ST_BUSY;
      end
      qstp_pkg::MODE_LOAD: begin
        if (mode_q == qstp_pkg::PS_IDLE) st = qstp_pkg::ST_NOT_ACT;
        else if (mode_q == qstp_pkg::PS_WAIT) st = qstp_pkg::ST_WAITING;
        else if (r.id != 16'(act_q.id + 1)) st = qstp_pkg::ST_BAD_NEXT;
        else stage_segment(r, 0);
      end
      default: hold_q = 0;
    endcase
    s.pos = held_q; s.seg = shown_q; s.ps = mode_q; s.st = st;
    return s;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (valid_o && ready_i) begin
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pos=%h", position_o);
      end else begin
        sample_t e;
        e = pending_samples.pop_front();
        if (position_o !== e.pos || current_segment_o !== e.seg ||
            player_state_o !== e.ps || status_o !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp pos=%h seg=%0d ps=%0d st=%0d got pos=%h seg=%0d ps=%0d st=%0d",
                     e.pos, e.seg, e.ps, e.st, position_o, current_segment_o,
                     player_state_o, status_o);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    int gap;
    if (hold_off || !rst_ni) ready_i <= 1'b0;
    else if (quiet) ready_i <= 1'b1;
    else if (!ready_i) ready_i <= ($urandom_range(0, 3) == 0);
    else if ($urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      ready_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      ready_i <= 1'b1;
    end else ready_i <= 1'b1;
  end

  task automatic write_step(logic [23:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= STEP_ADDR; pwdata <= {8'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    step_q = v;
  endtask

  task automatic send(request_t r, bit use_gaps);
    if (use_gaps && !quiet && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    @(posedge clk_i);
    valid_i <= 1; mode_i <= r.mode; seg_id_i <= r.id; seg_duration_i <= r.dur;
    coeff_0_i <= r.c[0]; coeff_1_i <= r.c[1]; coeff_2_i <= r.c[2];
    coeff_3_i <= r.c[3]; coeff_4_i <= r.c[4]; coeff_5_i <= r.c[5];
    wait_for_sync_i <= r.sync;
    do @(posedge clk_i); while (!ready_o);
    pending_samples.push_back(predict_sample(r));
    valid_i <= 0;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic request_t make_req(qstp_pkg::mode_e m, logic [15:0] id, logic [31:0] d,
                                        logic signed [31:0] cv, bit sy);
    request_t r;
    r.mode = m; r.id = id; r.dur = d; r.sync = sy;
    for (int k = 0; k < qstp_pkg::NCOEF; k++) r.c[k] = cv;
    return r;
  endfunction

  function automatic request_t rand_req(qstp_pkg::mode_e m, logic [15:0] id, bit wide);
    request_t r;
    r.mode = m; r.id = id; r.sync = $urandom_range(0, 3) == 0;
    r.dur = wide ? $urandom() : 32'($urandom_range(0, 6) * step_q);
    if ($urandom_range(0, 19) == 0) r.dur = 0;
    for (int k = 0; k < qstp_pkg::NCOEF; k++)
      r.c[k] = $urandom_range(0, 3) == 0 ? $urandom() :
               32'($signed($urandom_range(0, 2**20)) - 2**19);
    return r;
  endfunction

  // a chain: start, loads with correct ids, ticks, odd noise
  task automatic run_chain(bit wide);
    logic [15:0] nid;
    qstp_pkg::mode_e m;
    send(rand_req(qstp_pkg::MODE_START, 16'(qstp_pkg::START_ID), wide), 1);
    nid = 16'(qstp_pkg::START_ID + 1);
    for (int i = 0; i < 20; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send(rand_req(qstp_pkg::MODE_TICK, 16'($urandom()), wide), 1);
        5, 6: send(rand_req(qstp_pkg::MODE_LOAD, nid, wide), 1);
        7: send(rand_req(qstp_pkg::MODE_SYNC, 16'($urandom()), wide), 1);
        default: begin
          m = qstp_pkg::mode_e'($urandom_range(0, 3));
          send(rand_req(m, 16'($urandom()), 1), 1);
        end
      endcase
      if (mode_q == qstp_pkg::PS_ACTIVE) nid = 16'(act_q.id + 1);
    end
  endtask

  request_t dir_tab[$];
  sample_t dir_exp[$];

  initial begin
    player_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset reads, every error code, extremes
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_LOAD, 3, 5, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_START, 16'hFFFF, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_SYNC, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_START, 16'(qstp_pkg::START_ID), 32'hFFFF_FFFF,
                               32'sh7FFF_FFFF, 1));
    dir_tab.push_back(make_req(qstp_pkg::MODE_START, 16'(qstp_pkg::START_ID), 32'd1,
                               32'sh8000_0000, 1));
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_START, 16'(qstp_pkg::START_ID), 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_LOAD, 3, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_SYNC, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_START, 16'(qstp_pkg::START_ID), 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_LOAD, 4, 9, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_LOAD, 3, 32'h0100_0000, 32'sh7FFF_FFFF, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_LOAD, 3, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    dir_tab.push_back(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0));
    // typed expectations for the rows that read off directly; rest use predictor only
    dir_exp.push_back('{0, 0, qstp_pkg::PS_IDLE, qstp_pkg::ST_OK});
    dir_exp.push_back('{0, 0, qstp_pkg::PS_IDLE, qstp_pkg::ST_NOT_ACT});
    dir_exp.push_back('{0, 0, qstp_pkg::PS_IDLE, qstp_pkg::ST_BAD_START});
    dir_exp.push_back('{0, 0, qstp_pkg::PS_IDLE, qstp_pkg::ST_OK});
    dir_exp.push_back('{0, 0, qstp_pkg::PS_IDLE, qstp_pkg::ST_OK});
    dir_exp.push_back('{0, 0, qstp_pkg::PS_IDLE, qstp_pkg::ST_OK});
    dir_exp.push_back('{0, 1, qstp_pkg::PS_WAIT, qstp_pkg::ST_OK});
    dir_exp.push_back('{0, 1, qstp_pkg::PS_WAIT, qstp_pkg::ST_WAITING});
    dir_exp.push_back('{0, 1, qstp_pkg::PS_WAIT, qstp_pkg::ST_WAITING});
    for (int i = 0; i < dir_tab.size(); i++) begin
      send(dir_tab[i], 0);
      if (i < dir_exp.size() && pending_samples[$] != dir_exp[i]) begin
        errors++;
        if (errors <= 10) $display("directed row %0d disagrees with table", i);
      end
    end
    drain();

    write_step(24'hFF_FFFF);
    for (int i = 0; i < 4; i++) run_chain(1);
    drain();
    write_step(24'd1);
    for (int i = 0; i < 3; i++) run_chain(1);
    drain();
    write_step(24'd0);
    run_chain(0);
    send(make_req(qstp_pkg::MODE_START, 16'(qstp_pkg::START_ID), 0, 0, 0), 1);
    send(make_req(qstp_pkg::MODE_TICK, 0, 0, 0, 0), 1);
    drain();

    // long receiver hold-off so the block backs up and stalls the sender
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send(rand_req(qstp_pkg::MODE_TICK, 0, 0), 0);
    join
    drain();

    write_step(24'd16777);
    for (int i = 0; i < 28; i++) run_chain($urandom_range(0, 1));
    drain();
    write_step(24'($urandom_range(1, 24'hFF_FFFF)));
    quiet = 1'b1;
    for (int i = 0; i < 12; i++) run_chain($urandom_range(0, 1));
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
hdl/qstp_pkg.sv
hdl/qstp_horner.sv
hdl/quintic_segment_trajectory_player.sv
test/quintic_segment_trajectory_player_tb.sv
